/* src/bvl_pkg.sv */
`default_nettype none
package bvl_pkg;

   localparam int DEPTH_DEFAULT = 32;
   localparam int VALUE_W       = 32;
   localparam int REQ_W         = 2;
   localparam int RSP_CNT_W     = 6;

   typedef enum logic [REQ_W-1:0] {
      REQ_INSERT       = 2'd0,
      REQ_REMOVE_FIRST = 2'd1,
      REQ_REMOVE_ALL   = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic issue;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic rd_pend;
   } dp_status_type;

endpackage
`default_nettype wire

/* src/bvl_ctrl.sv */
`default_nettype none
module bvl_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire bvl_pkg::dp_status_type status,
   output bvl_pkg::ctrl_cmd_type     cmd
);
   import bvl_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      busy       = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.issue = 1'b1;
            // wait for the last read to be processed
            if (status.scan_done && !status.rd_pend) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

/* src/bvl_datapath.sv */
`default_nettype none
module bvl_datapath #(
   parameter int DEPTH = bvl_pkg::DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [bvl_pkg::REQ_W-1:0]           req_type,
   input  wire logic signed [bvl_pkg::VALUE_W-1:0]  req_value,
   input  wire bvl_pkg::ctrl_cmd_type               cmd,
   output bvl_pkg::dp_status_type                   status,
   output logic                                     rsp_valid,
   output logic                                     rsp_ok,
   output logic [bvl_pkg::RSP_CNT_W-1:0]            rsp_removed_count,
   output logic [bvl_pkg::RSP_CNT_W-1:0]            rsp_size,
   output logic                                     rsp_is_empty,
   output logic                                     rsp_is_full,
   output logic signed [bvl_pkg::VALUE_W-1:0]       rsp_min_value
);
   import bvl_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   logic [VALUE_W-1:0] mem [DEPTH];

   logic [CW-1:0]              count_ff, count_in;
   logic [CW-1:0]              idx_ff, idx_in;
   logic [CW-1:0]              w_ff, w_in;
   logic [CW-1:0]              removed_ff, removed_in;
   logic [REQ_W-1:0]           op_ff, op_in;
   logic signed [VALUE_W-1:0]  val_ff, val_in;
   logic signed [VALUE_W-1:0]  carry_ff, carry_in;
   logic signed [VALUE_W-1:0]  min_ff, min_in;
   logic                       have_min_ff, have_min_in;
   logic                       found_ff, found_in;
   logic                       rd_pend_ff, rd_pend_in;
   logic signed [VALUE_W-1:0]  rd_data_ff;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_ok_ff, rsp_ok_in;
   logic [RSP_CNT_W-1:0]       rsp_removed_ff, rsp_removed_in;
   logic [RSP_CNT_W-1:0]       rsp_size_ff, rsp_size_in;
   logic                       rsp_empty_ff, rsp_empty_in;
   logic                       rsp_full_ff, rsp_full_in;
   logic signed [VALUE_W-1:0]  rsp_min_ff, rsp_min_in;

   logic                       insert_ok;
   logic                       is_remove;
   logic                       rd_issue;
   logic                       drop;
   logic                       keep;
   logic                       wr_en;
   logic [CW-1:0]              wr_addr;
   logic [VALUE_W-1:0]         wr_data;

   assign insert_ok = (op_ff == REQ_INSERT) && (count_ff < FULL_CNT);
   assign is_remove = (op_ff == REQ_REMOVE_FIRST) || (op_ff == REQ_REMOVE_ALL);
   assign rd_issue  = cmd.issue && (idx_ff < count_ff);

   // remove-first drops only the first match, remove-all drops every match
   assign drop = rd_pend_ff && (rd_data_ff == val_ff) &&
                 ((op_ff == REQ_REMOVE_ALL) || ((op_ff == REQ_REMOVE_FIRST) && !found_ff));
   assign keep = rd_pend_ff && !drop;

   assign status.scan_done = (idx_ff >= count_ff);
   assign status.rd_pend   = rd_pend_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = w_ff;
      wr_data = carry_ff;
      priority if (cmd.finish && insert_ok) begin
         // tail entry of the shift moves into the new last slot
         wr_en   = 1'b1;
         wr_addr = count_ff;
      end else if (rd_pend_ff && insert_ok) begin
         wr_en = 1'b1;
      end else if (keep && is_remove) begin
         wr_en   = 1'b1;
         wr_data = rd_data_ff;
      end else begin
         wr_en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr[AW-1:0]] <= wr_data;
      end
      if (rd_issue) begin
         rd_data_ff <= mem[idx_ff[AW-1:0]];
      end
   end

   always_comb begin
      count_in       = count_ff;
      idx_in         = idx_ff;
      w_in           = w_ff;
      removed_in     = removed_ff;
      op_in          = op_ff;
      val_in         = val_ff;
      carry_in       = carry_ff;
      min_in         = min_ff;
      have_min_in    = have_min_ff;
      found_in       = found_ff;
      rd_pend_in     = rd_issue;
      rsp_valid_in   = cmd.finish;
      rsp_ok_in      = rsp_ok_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_size_in    = rsp_size_ff;
      rsp_empty_in   = rsp_empty_ff;
      rsp_full_in    = rsp_full_ff;
      rsp_min_in     = rsp_min_ff;

      if (cmd.load) begin
         idx_in      = '0;
         w_in        = '0;
         removed_in  = '0;
         found_in    = 1'b0;
         op_in       = req_type;
         val_in      = req_value;
         carry_in    = req_value;
         min_in      = req_value;
         have_min_in = (req_type == REQ_INSERT) && (count_ff < FULL_CNT);
      end

      if (rd_issue) begin
         idx_in = idx_ff + CW'(1);
      end

      if (rd_pend_ff) begin
         carry_in = rd_data_ff;
         if (keep) begin
            w_in = w_ff + CW'(1);
            if (!have_min_ff || (rd_data_ff < min_ff)) begin
               min_in      = rd_data_ff;
               have_min_in = 1'b1;
            end
         end else begin
            removed_in = removed_ff + CW'(1);
            found_in   = 1'b1;
         end
      end

      if (cmd.finish) begin
         priority if (insert_ok) begin
            count_in = count_ff + CW'(1);
         end else if (is_remove) begin
            count_in = w_ff;
         end else begin
            count_in = count_ff;
         end
         unique case (op_ff)
            REQ_INSERT:       rsp_ok_in = insert_ok;
            REQ_REMOVE_FIRST: rsp_ok_in = found_ff;
            REQ_REMOVE_ALL:   rsp_ok_in = (count_ff != '0);
            default:          rsp_ok_in = 1'b0;
         endcase
         rsp_removed_in = RSP_CNT_W'(removed_ff);
         rsp_size_in    = RSP_CNT_W'(count_in);
         rsp_empty_in   = (count_in == '0);
         rsp_full_in    = (count_in == FULL_CNT);
         rsp_min_in     = have_min_ff ? min_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      w_ff           <= w_in;
      removed_ff     <= removed_in;
      op_ff          <= op_in;
      val_ff         <= val_in;
      carry_ff       <= carry_in;
      min_ff         <= min_in;
      have_min_ff    <= have_min_in;
      found_ff       <= found_in;
      rsp_ok_ff      <= rsp_ok_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_size_ff    <= rsp_size_in;
      rsp_empty_ff   <= rsp_empty_in;
      rsp_full_ff    <= rsp_full_in;
      rsp_min_ff     <= rsp_min_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_removed_count = rsp_removed_ff;
   assign rsp_size          = rsp_size_ff;
   assign rsp_is_empty      = rsp_empty_ff;
   assign rsp_is_full       = rsp_full_ff;
   assign rsp_min_value     = rsp_min_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count beyond depth");

   a_read_in_list: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> ($past(idx_ff) < count_ff))
      else $error("read outside the stored list");

   a_write_in_list: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wr_addr <= count_ff) && (wr_addr < FULL_CNT))
      else $error("write beyond list end");

endmodule
`default_nettype wire

/* src/bounded_value_list_top.sv */
// channel   | ports                                        | handshake
// ----------+----------------------------------------------+-----------------------------
// request   | req_type, req_value                          | taken when start & !busy
// response  | rsp_ok, rsp_removed_count, rsp_size,         | rsp_valid high for one cycle
//           | rsp_is_empty, rsp_is_full, rsp_min_value     |
//
// a transaction runs from acceptance through one memory read per stored entry
// of the list as it was before the request, then one drain, one end-of-scan
// check, one finish and one response step; the next request can be taken
// in the response step. an empty list skips the reads and the drain.
// busy drops in the same cycle as the response shows.
// synchronous reset empties the list; entry storage is not cleared.
// the receiver cannot stall: each response is held for exactly one cycle.
`default_nettype none
module bounded_value_list_top #(
   parameter int DEPTH = bvl_pkg::DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [bvl_pkg::REQ_W-1:0]           req_type,
   input  wire logic signed [bvl_pkg::VALUE_W-1:0]  req_value,
   output logic                                     rsp_valid,
   output logic                                     rsp_ok,
   output logic [bvl_pkg::RSP_CNT_W-1:0]            rsp_removed_count,
   output logic [bvl_pkg::RSP_CNT_W-1:0]            rsp_size,
   output logic                                     rsp_is_empty,
   output logic                                     rsp_is_full,
   output logic signed [bvl_pkg::VALUE_W-1:0]       rsp_min_value
);
   import bvl_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   bvl_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   bvl_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_type          (req_type),
      .req_value         (req_value),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_ok            (rsp_ok),
      .rsp_removed_count (rsp_removed_count),
      .rsp_size          (rsp_size),
      .rsp_is_empty      (rsp_is_empty),
      .rsp_is_full       (rsp_is_full),
      .rsp_min_value     (rsp_min_value)
   );

endmodule
`default_nettype wire
